// ===== rtl/deq_pkg.sv =====
// Package for the double-ended queue: request and response structs,
// opcode and state enums, and default sizes.
// No dependencies; used by the queue top level.
package deq_pkg;

  // Field widths of the request and response ports
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 5;
  localparam int OP_W    = 3;

  // Default sizes for the ring store
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_FILL = 1'b1
  } state_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [WORD_W-1:0]  push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    logic                      pop_on_empty;
    logic                      push_dropped;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
    logic                      is_empty;
    logic [CNT_W-1:0]          entry_count;
  } out_rsp_t;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue over a ring store; uses deq_pkg and deq_ram.
// The response is registered: it is valid in the cycle after the request is taken. A pop
// that leaves two or more words first passes through the fill state, which takes the ring
// store read of the new end word. One request per cycle otherwise, while output is not stalled.
// Reset clears head index, count and output valid; the ring store is not
// cleared and needs no clearing pass.
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::out_rsp_t out_rsp
);

  localparam int AW  = $clog2(DEPTH);
  localparam int SW  = AW + 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int DW  = DATA_WIDTH;
  localparam int OW  = deq_pkg::WORD_W;
  localparam int OCW = deq_pkg::CNT_W;
  localparam int XW  = (DW > OW) ? DW : OW;

  // Ring position head + off, wrapped once
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h,
                                              input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Fit a stored word to the response field width
  function automatic logic [OW-1:0] widen(input logic [DW-1:0] w);
    logic [XW-1:0] t;
    t = XW'(w);
    return t[OW-1:0];
  endfunction

  deq_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     front_r, front_nxt;
  logic [DW-1:0]     back_r, back_nxt;
  logic [DW-1:0]     popped_r, popped_nxt;
  logic              pop_empty_r, pop_empty_nxt;
  logic              dropped_r, dropped_nxt;
  logic              fill_front_r, fill_front_nxt;
  deq_pkg::out_rsp_t out_rsp_r, rsp_nxt;
  logic              out_load;

  logic              accept;
  logic [DW-1:0]     push_word;
  logic              is_full;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DW-1:0]     rd_data;

  assign in_stall  = (state_r != deq_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign push_word = DW'(in_req.push_value);
  assign is_full   = (count_r == CW'(DEPTH));
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  deq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Command decode, end-word tracking and ring store access
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    popped_nxt     = popped_r;
    pop_empty_nxt  = pop_empty_r;
    dropped_nxt    = dropped_r;
    fill_front_nxt = fill_front_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_load       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;

    case (state_r)
      deq_pkg::ST_IDLE: begin
        if (accept) begin
          popped_nxt    = '1;
          pop_empty_nxt = 1'b0;
          dropped_nxt   = 1'b0;
          case (in_req.opcode)
            deq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                dropped_nxt = 1'b1;
              end else begin
                head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                wr_en     = 1'b1;
                wr_addr   = head_nxt;
                count_nxt = count_r + CW'(1);
                front_nxt = push_word;
                if (count_r == '0) begin
                  back_nxt = push_word;
                end
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                dropped_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ring_pos(head_r, count_r);
                count_nxt = count_r + CW'(1);
                back_nxt  = push_word;
                if (count_r == '0) begin
                  front_nxt = push_word;
                end
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (count_r == '0) begin
                pop_empty_nxt = 1'b1;
              end else begin
                popped_nxt = front_r;
                head_nxt   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
                count_nxt  = count_r - CW'(1);
                if (count_nxt == CW'(1)) begin
                  front_nxt = back_r;
                end else if (count_nxt > CW'(1)) begin
                  // fetch the new front word
                  rd_en          = 1'b1;
                  rd_addr        = head_nxt;
                  fill_front_nxt = 1'b1;
                end
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (count_r == '0) begin
                pop_empty_nxt = 1'b1;
              end else begin
                popped_nxt = back_r;
                count_nxt  = count_r - CW'(1);
                if (count_nxt == CW'(1)) begin
                  back_nxt = front_r;
                end else if (count_nxt > CW'(1)) begin
                  // fetch the new back word
                  rd_en          = 1'b1;
                  rd_addr        = ring_pos(head_r, count_nxt - CW'(1));
                  fill_front_nxt = 1'b0;
                end
              end
            end
            deq_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          if (rd_en) begin
            state_nxt = deq_pkg::ST_FILL;
          end else begin
            out_valid_nxt = 1'b1;
            out_load      = 1'b1;
          end
        end
      end
      deq_pkg::ST_FILL: begin
        // take the read word as the new end and issue the response
        if (fill_front_r) begin
          front_nxt = rd_data;
        end else begin
          back_nxt = rd_data;
        end
        out_valid_nxt = 1'b1;
        out_load      = 1'b1;
        state_nxt     = deq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // Assemble the response from the updated queue
  always_comb begin
    rsp_nxt.popped_value = widen(popped_nxt);
    rsp_nxt.pop_on_empty = pop_empty_nxt;
    rsp_nxt.push_dropped = dropped_nxt;
    rsp_nxt.is_empty     = (count_nxt == '0);
    rsp_nxt.entry_count  = OCW'(count_nxt);
    if (count_nxt == '0) begin
      rsp_nxt.front_value = widen('1);
      rsp_nxt.back_value  = widen('1);
    end else begin
      rsp_nxt.front_value = widen(front_nxt);
      rsp_nxt.back_value  = widen(back_nxt);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: end words, pending response parts, output slot
  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    popped_r     <= popped_nxt;
    pop_empty_r  <= pop_empty_nxt;
    dropped_r    <= dropped_nxt;
    fill_front_r <= fill_front_nxt;
    if (out_load) begin
      out_rsp_r <= rsp_nxt;
    end
  end

endmodule

// ===== tb/sv/double_ended_queue_test.sv =====
// Self-checking bench for the double_ended_queue block: directed table, then random commands.
// Responses are checked against fixed table values or a ring-buffer predictor in the bench.
// Depends on deq_pkg and the double_ended_queue RTL.
module double_ended_queue_test;

  localparam int DEPTH         = deq_pkg::DEPTH_DEF;
  localparam int OP_W          = deq_pkg::OP_W;
  localparam int WORD_W        = deq_pkg::WORD_W;
  localparam int CNT_W         = deq_pkg::CNT_W;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int IDLE_PERCENT  = 37;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // Opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic signed [WORD_W-1:0] NO_WORD  = -1;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef struct {
    deq_pkg::in_req_t  req;
    bit                fixed;
    deq_pkg::out_rsp_t want;
  } table_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  deq_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  deq_pkg::out_rsp_t out_rsp;

  // Predictor state: ring words, front position and fill level
  logic signed [WORD_W-1:0] ring_word [DEPTH];
  int         ring_head = 0;
  int         ring_fill = 0;

  deq_pkg::out_rsp_t pending_results [$];
  table_row_t        request_table [$];
  int         errors = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  double_ended_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always #6 clk = ~clk;

  function automatic deq_pkg::out_rsp_t make_rsp(input logic signed [WORD_W-1:0] popped,
                                                 input bit pop_empty, input bit dropped,
                                                 input logic signed [WORD_W-1:0] front,
                                                 input logic signed [WORD_W-1:0] back,
                                                 input bit empty, input int count);
    deq_pkg::out_rsp_t rsp;
    rsp.popped_value = popped;
    rsp.pop_on_empty = pop_empty;
    rsp.push_dropped = dropped;
    rsp.front_value  = front;
    rsp.back_value   = back;
    rsp.is_empty     = empty;
    rsp.entry_count  = CNT_W'(count);
    return rsp;
  endfunction

  // Apply one command to the ring and return the response it should give
  function automatic deq_pkg::out_rsp_t predict_deque(input deq_pkg::in_req_t req);
    deq_pkg::out_rsp_t rsp;
    rsp = make_rsp(NO_WORD, 1'b0, 1'b0, NO_WORD, NO_WORD, 1'b1, 0);
    case (req.opcode)
      deq_pkg::OP_PUSH_FRONT: begin
        if (ring_fill == DEPTH) begin
          rsp.push_dropped = 1'b1;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_word[ring_head] = req.push_value;
          ring_fill++;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (ring_fill == DEPTH) begin
          rsp.push_dropped = 1'b1;
        end else begin
          ring_word[(ring_head + ring_fill) % DEPTH] = req.push_value;
          ring_fill++;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          rsp.pop_on_empty = 1'b1;
        end else begin
          rsp.popped_value = ring_word[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (ring_fill == 0) begin
          rsp.pop_on_empty = 1'b1;
        end else begin
          rsp.popped_value = ring_word[(ring_head + ring_fill - 1) % DEPTH];
          ring_fill--;
        end
      end
      deq_pkg::OP_CLEAR: ring_fill = 0;
      default: ;
    endcase
    if (ring_fill != 0) begin
      rsp.front_value = ring_word[ring_head];
      rsp.back_value  = ring_word[(ring_head + ring_fill - 1) % DEPTH];
    end
    rsp.is_empty    = (ring_fill == 0);
    rsp.entry_count = CNT_W'(ring_fill);
    return rsp;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op,
                                  input logic signed [WORD_W-1:0] value,
                                  input bit fixed, input deq_pkg::out_rsp_t want);
    table_row_t row;
    row.req.opcode     = deq_pkg::opcode_t'(op);
    row.req.push_value = value;
    row.fixed          = fixed;
    row.want           = want;
    request_table.insert(request_table.size(), row);
  endfunction

  // Mostly full-range words, with the extremes mixed in
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(19))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return NO_WORD;
      default: return $urandom;
    endcase
  endfunction

  // Pick a command; push_share sets the percentage of pushes
  function automatic table_row_t random_row(input int push_share);
    table_row_t  row;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2)
      row.req.opcode = deq_pkg::OP_CLEAR;
    else if (roll < 5)
      row.req.opcode = deq_pkg::opcode_t'($urandom_range(OP_RSVD_7, OP_RSVD_5));
    else if (roll < 5 + push_share)
      row.req.opcode = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    else
      row.req.opcode = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
    row.req.push_value = random_word();
    row.fixed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned n;
    n = 0;
    if (!calm) begin
      while (n < 20 && $urandom_range(99) < IDLE_PERCENT) n++;
    end
    return n;
  endfunction

  // Present one request, hold it until taken, then record its response
  task automatic issue_request(input table_row_t row);
    int unsigned       gap;
    deq_pkg::out_rsp_t predicted;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= row.req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_deque(row.req);
    pending_results.insert(pending_results.size(), row.fixed ? row.want : predicted);
  endtask

  task automatic report_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    errors++;
  endtask

  task automatic compare_result(input deq_pkg::out_rsp_t want, input deq_pkg::out_rsp_t got);
    if (got.popped_value !== want.popped_value)
      report_field("popped_value", want.popped_value, got.popped_value);
    if (got.pop_on_empty !== want.pop_on_empty)
      report_field("pop_on_empty", WORD_W'(want.pop_on_empty), WORD_W'(got.pop_on_empty));
    if (got.push_dropped !== want.push_dropped)
      report_field("push_dropped", WORD_W'(want.push_dropped), WORD_W'(got.push_dropped));
    if (got.front_value !== want.front_value)
      report_field("front_value", want.front_value, got.front_value);
    if (got.back_value !== want.back_value)
      report_field("back_value", want.back_value, got.back_value);
    if (got.is_empty !== want.is_empty)
      report_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
    if (got.entry_count !== want.entry_count)
      report_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
  endtask

  // Stall the response side at random, except during the calm stretch
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
  end

  // Check each taken response against the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual %p", $time, out_rsp);
        errors++;
      end else begin
        compare_result(pending_results[0], out_rsp);
        pending_results.delete(0);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int push_share;

    // Directed table: empty pops, no-op codes, extremes, wrap, full, clear
    add_row(deq_pkg::OP_POP_FRONT, 32'h1234_5678, 1'b1,
            make_rsp(NO_WORD, 1'b1, 1'b0, NO_WORD, NO_WORD, 1'b1, 0));
    add_row(OP_RSVD_5, WORD_MAX, 1'b1,
            make_rsp(NO_WORD, 1'b0, 1'b0, NO_WORD, NO_WORD, 1'b1, 0));
    add_row(deq_pkg::OP_PUSH_BACK, WORD_MAX, 1'b1,
            make_rsp(NO_WORD, 1'b0, 1'b0, WORD_MAX, WORD_MAX, 1'b0, 1));
    add_row(deq_pkg::OP_PUSH_FRONT, WORD_MIN, 1'b1,
            make_rsp(NO_WORD, 1'b0, 1'b0, WORD_MIN, WORD_MAX, 1'b0, 2));
    add_row(OP_RSVD_6, 32'h0f0f_0f0f, 1'b0, '0);
    add_row(deq_pkg::OP_POP_FRONT, '0, 1'b1,
            make_rsp(WORD_MIN, 1'b0, 1'b0, WORD_MAX, WORD_MAX, 1'b0, 1));
    add_row(deq_pkg::OP_POP_BACK, NO_WORD, 1'b1,
            make_rsp(WORD_MAX, 1'b0, 1'b0, NO_WORD, NO_WORD, 1'b1, 0));
    add_row(deq_pkg::OP_POP_BACK, WORD_MIN, 1'b1,
            make_rsp(NO_WORD, 1'b1, 1'b0, NO_WORD, NO_WORD, 1'b1, 0));
    add_row(deq_pkg::OP_PUSH_FRONT, '0, 1'b0, '0);
    add_row(deq_pkg::OP_PUSH_BACK, NO_WORD, 1'b0, '0);
    add_row(deq_pkg::OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0);
    add_row(deq_pkg::OP_PUSH_BACK, 32'haaaa_aaaa, 1'b0, '0);
    for (int i = 0; i < DEPTH - 4; i++)
      add_row(i % 2 ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
              32'h0101_0101 * (i + 1), 1'b0, '0);
    // Full: both pushes are dropped
    add_row(deq_pkg::OP_PUSH_BACK, 32'hdead_beef, 1'b0, '0);
    add_row(deq_pkg::OP_PUSH_FRONT, 32'hcafe_f00d, 1'b0, '0);
    add_row(deq_pkg::OP_CLEAR, WORD_MAX, 1'b1,
            make_rsp(NO_WORD, 1'b0, 1'b0, NO_WORD, NO_WORD, 1'b1, 0));
    add_row(OP_RSVD_7, WORD_MIN, 1'b1,
            make_rsp(NO_WORD, 1'b0, 1'b0, NO_WORD, NO_WORD, 1'b1, 0));

    // Hold reset, then release
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (request_table[i]) issue_request(request_table[i]);

    // Random commands in blocks that fill, drain, or hover
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 400 && n < 600);
      case ((n / 50) % 3)
        0: push_share = 75;
        1: push_share = 20;
        default: push_share = 47;
      endcase
      issue_request(random_row(push_share));
    end
    in_valid <= 1'b0;

    // Drain outstanding responses, then let the pipeline settle
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
